>>> sv/gbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbm_pkg
// Shared types, constants and command codes of the Gaussian pair generator.
// ----------------------------------------------------------------------------
package gbm_pkg;

   // input word: optional reseed
   typedef struct packed {
      logic        load_seed;
      logic [63:0] seed;
   } req_word_type;

   // result word: two normal samples in Q5.26
   typedef struct packed {
      logic signed [31:0] gauss_a;
      logic signed [31:0] gauss_b;
   } rsp_word_type;

   // generator constants
   localparam logic [63:0] GOLD = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MULA = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MULB = 64'h94d049bb133111eb;
   localparam logic [52:0] MIN_CODE = 53'd9;

   // fixed point constants
   localparam logic [28:0] TWO_LN2_Q28 = 29'd372130559;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic signed [33:0] CORDIC_K_Q30 = 34'sd652032874;
   localparam logic [4:0] CORDIC_STEPS = 5'd30;

   // last step indices of the sequencer loops
   localparam logic [4:0] MIX_LAST = 5'd6;
   localparam logic [4:0] NORM_LAST = 5'd5;
   localparam logic [4:0] ITER_LAST = 5'd31;

   // datapath operations
   typedef enum logic [4:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_SEED_LOAD,
      OP_DRAW_LOAD,
      OP_MUL_LL,
      OP_MUL_LH,
      OP_MUL_HL_X27,
      OP_MUL_FIN,
      OP_PREP,
      OP_NORM_STEP,
      OP_LOG_INIT,
      OP_LOG_STEP,
      OP_RAD,
      OP_SQRT_STEP,
      OP_SCALE_A,
      OP_SCALE_B,
      OP_OUT
   } dp_op_type;

   // destination of a finished mix
   typedef enum logic [1:0] {
      DST_STATE,
      DST_K0,
      DST_K1
   } mix_dst_type;

   // command from controller to datapath
   typedef struct packed {
      dp_op_type   op;
      logic        use_b;
      mix_dst_type dst;
      logic [4:0]  idx;
   } cmd_type;

   // truncated atan(2^-i) in Q.30
   function automatic logic [29:0] atan_q30(input logic [4:0] i);
      logic [29:0] v;
      unique case (i)
         5'd0:  v = 30'd843314856;
         5'd1:  v = 30'd497837829;
         5'd2:  v = 30'd263043836;
         5'd3:  v = 30'd133525158;
         5'd4:  v = 30'd67021686;
         5'd5:  v = 30'd33543515;
         5'd6:  v = 30'd16775850;
         5'd7:  v = 30'd8388437;
         5'd8:  v = 30'd4194282;
         5'd9:  v = 30'd2097149;
         5'd10: v = 30'd1048575;
         5'd11: v = 30'd524287;
         5'd12: v = 30'd262143;
         5'd13: v = 30'd131071;
         5'd14: v = 30'd65535;
         5'd15: v = 30'd32767;
         5'd16: v = 30'd16383;
         5'd17: v = 30'd8191;
         5'd18: v = 30'd4095;
         5'd19: v = 30'd2047;
         5'd20: v = 30'd1023;
         5'd21: v = 30'd511;
         5'd22: v = 30'd255;
         5'd23: v = 30'd127;
         5'd24: v = 30'd63;
         5'd25: v = 30'd31;
         5'd26: v = 30'd15;
         5'd27: v = 30'd7;
         5'd28: v = 30'd3;
         5'd29: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

>>> sv/gaussian_pair_box_muller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_pair_box_muller
// Gaussian noise source: splitmix64 generator and fixed-point Box-Muller.
// ----------------------------------------------------------------------------
// Usage: each word accepted on req (valid/ready) yields exactly one word on
// rsp holding two standard normal samples in signed Q5.26. If load_seed is
// set the generator is reseeded from seed before drawing; otherwise seed is
// ignored.
// A new word is taken only when the sequencer is idle, so it is not accepted
// until the sequencer is through with the last word. The work per word is set by
// two or three 64-bit multiply-mix passes on one shared 32x32 multiplier,
// a 32-round log2 squaring loop that runs alongside the 30-step CORDIC, and a
// 32-step bit-serial square root.
// The result sits in an output register: the next word is accepted and
// processed while it waits; the sequencer holds its finished result until
// rsp_ready frees the register.
// Reset (synchronous) clears the generator state to zero and drops rsp_valid.
// ----------------------------------------------------------------------------
module gaussian_pair_box_muller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  gbm_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output gbm_pkg::rsp_word_type rsp_word
);
   import gbm_pkg::*;

   cmd_type cmd;

   // sequencer
   gbm_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_load_seed (req_word.load_seed),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .cmd           (cmd)
   );

   // arithmetic
   gbm_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_word (req_word),
      .rsp_word (rsp_word)
   );

endmodule

>>> sv/gbm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbm_datapath
// Generator state, mixer with shared 32x32 multiplier, log2, square root,
// CORDIC and output scaling, one operation per cycle under command.
// ----------------------------------------------------------------------------
module gbm_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  gbm_pkg::cmd_type     cmd,
   input  gbm_pkg::req_word_type req_word,
   output gbm_pkg::rsp_word_type rsp_word
);
   import gbm_pkg::*;

   logic [63:0] gen_ff, gen_in;
   logic [63:0] seed_ff, seed_in;
   logic [63:0] z_ff, z_in;
   logic [63:0] acc_ff, acc_in;
   logic [52:0] k0_ff, k0_in;
   logic [52:0] k1_ff, k1_in;
   logic [63:0] norm_ff, norm_in;
   logic [5:0]  e_ff, e_in;
   logic [31:0] m_ff, m_in;
   logic [31:0] bits_ff, bits_in;
   logic [30:0] t_ff, t_in;
   logic [1:0]  q_ff, q_in;
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic [63:0] sq_v_ff, sq_v_in, sq_res_ff, sq_res_in, sq_bit_ff, sq_bit_in;
   logic [31:0] sa_ff, sa_in, sb_ff, sb_in;
   rsp_word_type out_ff, out_in;

   logic [63:0] mul_k, mix_w, mix_t, mix_r, mul_p;
   logic [31:0] mul_x, mul_y;
   logic [52:0] kc;
   logic [60:0] ang_p;
   logic [63:0] lsq;
   logic [32:0] lsh;
   logic [37:0] l2, dd;
   logic [62:0] rp, rps;
   logic [63:0] rb;
   logic signed [33:0] xs, ys, at, ca, cb, comp;
   logic [33:0] mag;
   logic [63:0] sp;
   logic [64:0] sps;
   logic [31:0] sv;

   // shared mixer multiplier, low 64 bits of z times constant in three parts
   always_comb begin
      mul_k = cmd.use_b ? MULB : MULA;
      mul_x = (cmd.op == OP_MUL_HL_X27 || cmd.op == OP_MUL_FIN) ? z_ff[63:32] : z_ff[31:0];
      mul_y = (cmd.op == OP_MUL_LH) ? mul_k[63:32] : mul_k[31:0];
      mul_p = {32'd0, mul_x} * {32'd0, mul_y};
      mix_t = acc_ff + {mul_p[31:0], 32'd0};
      mix_r = mix_t ^ (mix_t >> 31);
      mix_w = ((cmd.op == OP_SEED_LOAD) ? seed_ff : gen_ff) + GOLD;
   end

   // front end of log and angle, radius product and root trial term
   always_comb begin
      kc = (k0_ff < MIN_CODE) ? MIN_CODE : k0_ff;
      ang_p = {31'd0, k1_ff[50:21]} * {30'd0, HALF_PI_Q30};
      lsq = {32'd0, m_ff} * {32'd0, m_ff};
      lsh = lsq[63:31];
      l2 = {e_ff, bits_ff};
      dd = {6'd53, 32'd0} - l2;
      rp = {29'd0, dd[37:4]} * {34'd0, TWO_LN2_Q28};
      rps = rp + (63'd1 << 27);
      rb = sq_res_ff + sq_bit_ff;
   end

   // cordic step terms
   always_comb begin
      xs = cx_ff >>> cmd.idx;
      ys = cy_ff >>> cmd.idx;
      at = $signed({4'd0, atan_q30(cmd.idx)});
   end

   // quadrant fold and output scaling
   always_comb begin
      unique case (q_ff)
         2'd0: begin ca = cx_ff;  cb = cy_ff;  end
         2'd1: begin ca = -cy_ff; cb = cx_ff;  end
         2'd2: begin ca = -cx_ff; cb = -cy_ff; end
         default: begin ca = cy_ff; cb = -cx_ff; end
      endcase
      comp = (cmd.op == OP_SCALE_A) ? ca : cb;
      mag = comp[33] ? 34'(-comp) : 34'(comp);
      sp = {32'd0, sq_res_ff[31:0]} * {32'd0, mag[31:0]};
      sps = {1'b0, sp} + 65'(64'd1 << 31);
      sv = comp[33] ? 32'(-sps[63:32]) : sps[63:32];
   end

   // next state of every register
   always_comb begin
      gen_in = gen_ff; seed_in = seed_ff; z_in = z_ff; acc_in = acc_ff;
      k0_in = k0_ff; k1_in = k1_ff; norm_in = norm_ff; e_in = e_ff;
      m_in = m_ff; bits_in = bits_ff; t_in = t_ff; q_in = q_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff;
      sq_v_in = sq_v_ff; sq_res_in = sq_res_ff; sq_bit_in = sq_bit_ff;
      sa_in = sa_ff; sb_in = sb_ff; out_in = out_ff;
      unique case (cmd.op)
         OP_CAPTURE: seed_in = req_word.seed;
         OP_SEED_LOAD: z_in = mix_w ^ (mix_w >> 30);
         OP_DRAW_LOAD: begin
            gen_in = mix_w;
            z_in = mix_w ^ (mix_w >> 30);
         end
         OP_MUL_LL: acc_in = mul_p;
         OP_MUL_LH: acc_in = mix_t;
         OP_MUL_HL_X27: z_in = mix_t ^ (mix_t >> 27);
         OP_MUL_FIN: begin
            unique case (cmd.dst)
               DST_STATE: gen_in = mix_r;
               DST_K0: k0_in = mix_r[63:11];
               default: k1_in = mix_r[63:11];
            endcase
         end
         OP_PREP: begin
            norm_in = {kc, 11'd0};
            e_in = 6'd52;
            t_in = ang_p[60:30];
            q_in = k1_ff[52:51];
         end
         OP_NORM_STEP: begin
            // binary search for the leading one
            unique case (cmd.idx)
               5'd0: if (norm_ff[63:32] == 32'd0) begin
                  norm_in = norm_ff << 32; e_in = e_ff - 6'd32;
               end
               5'd1: if (norm_ff[63:48] == 16'd0) begin
                  norm_in = norm_ff << 16; e_in = e_ff - 6'd16;
               end
               5'd2: if (norm_ff[63:56] == 8'd0) begin
                  norm_in = norm_ff << 8; e_in = e_ff - 6'd8;
               end
               5'd3: if (norm_ff[63:60] == 4'd0) begin
                  norm_in = norm_ff << 4; e_in = e_ff - 6'd4;
               end
               5'd4: if (norm_ff[63:62] == 2'd0) begin
                  norm_in = norm_ff << 2; e_in = e_ff - 6'd2;
               end
               5'd5: if (!norm_ff[63]) begin
                  norm_in = norm_ff << 1; e_in = e_ff - 6'd1;
               end
               default: norm_in = norm_ff;
            endcase
         end
         OP_LOG_INIT: begin
            m_in = norm_ff[63:32];
            bits_in = 32'd0;
            cx_in = CORDIC_K_Q30;
            cy_in = 34'sd0;
            cz_in = $signed({3'd0, t_ff});
         end
         OP_LOG_STEP: begin
            // one squaring round of log2, and a cordic rotation alongside while idx < CORDIC_STEPS
            if (lsh[32]) begin
               m_in = lsh[32:1];
               bits_in = {bits_ff[30:0], 1'b1};
            end else begin
               m_in = lsh[31:0];
               bits_in = {bits_ff[30:0], 1'b0};
            end
            if (cmd.idx < CORDIC_STEPS) begin
               if (!cz_ff[33]) begin
                  cx_in = cx_ff - ys; cy_in = cy_ff + xs; cz_in = cz_ff - at;
               end else begin
                  cx_in = cx_ff + ys; cy_in = cy_ff - xs; cz_in = cz_ff + at;
               end
            end
         end
         OP_RAD: begin
            sq_v_in = {1'b0, rps[62:28], 28'd0};
            sq_res_in = 64'd0;
            sq_bit_in = 64'd1 << 62;
         end
         OP_SQRT_STEP: begin
            if (sq_v_ff >= rb) begin
               sq_v_in = sq_v_ff - rb;
               sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_in = sq_res_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
         end
         OP_SCALE_A: sa_in = sv;
         OP_SCALE_B: sb_in = sv;
         OP_OUT: begin
            out_in.gauss_a = sa_ff;
            out_in.gauss_b = sb_ff;
         end
         default: gen_in = gen_ff;
      endcase
   end

   // generator state
   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff <= 64'd0;
      end else begin
         gen_ff <= gen_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      seed_ff <= seed_in; z_ff <= z_in; acc_ff <= acc_in;
      k0_ff <= k0_in; k1_ff <= k1_in; norm_ff <= norm_in; e_ff <= e_in;
      m_ff <= m_in; bits_ff <= bits_in; t_ff <= t_in; q_ff <= q_in;
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in;
      sq_v_ff <= sq_v_in; sq_res_ff <= sq_res_in; sq_bit_ff <= sq_bit_in;
      sa_ff <= sa_in; sb_ff <= sb_in; out_ff <= out_in;
   end

   assign rsp_word = out_ff;

`ifndef SYNTHESIS
   // radius fits the 32-bit scaling multiplier
   a_rad_width: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_SCALE_A |-> sq_res_ff[63:32] == 32'd0)
      else $error("radius exceeds 32 bits");
   // normalization leaves the leading one at the top
   a_norm_top: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_LOG_INIT |-> norm_ff[63])
      else $error("mantissa not normalized");
   // the log mantissa stays in [1,2)
   a_log_range: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_LOG_STEP |-> m_ff[31])
      else $error("log mantissa out of range");
`endif

endmodule

>>> sv/gbm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbm_ctrl
// Sequencer: steps the datapath through reseed, two draws, log, root,
// rotation and scaling, and owns the handshakes.
// ----------------------------------------------------------------------------
module gbm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_load_seed,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gbm_pkg::cmd_type cmd
);
   import gbm_pkg::*;

   typedef enum logic [12:0] {
      ST_IDLE  = 13'b0000000000001,
      ST_SEED  = 13'b0000000000010,
      ST_DRAW0 = 13'b0000000000100,
      ST_DRAW1 = 13'b0000000001000,
      ST_PREP  = 13'b0000000010000,
      ST_NORM  = 13'b0000000100000,
      ST_LOGI  = 13'b0000001000000,
      ST_LOG   = 13'b0000010000000,
      ST_RAD   = 13'b0000100000000,
      ST_SQRT  = 13'b0001000000000,
      ST_SCA   = 13'b0010000000000,
      ST_SCB   = 13'b0100000000000,
      ST_OUT   = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_go;
   dp_op_type mix_op;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_go = !rsp_valid_ff || rsp_ready;

   // mix micro-step by count
   always_comb begin
      unique case (cnt_ff)
         5'd0: mix_op = (state_ff == ST_SEED) ? OP_SEED_LOAD : OP_DRAW_LOAD;
         5'd1, 5'd4: mix_op = OP_MUL_LL;
         5'd2, 5'd5: mix_op = OP_MUL_LH;
         5'd3: mix_op = OP_MUL_HL_X27;
         default: mix_op = OP_MUL_FIN;
      endcase
   end

   // next state and command
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op = OP_NONE;
      cmd.use_b = (cnt_ff > 5'd3);
      cmd.dst = DST_STATE;
      cmd.idx = cnt_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) begin
            cmd.op = OP_CAPTURE;
            cnt_in = 5'd0;
            state_in = req_load_seed ? ST_SEED : ST_DRAW0;
         end
         ST_SEED, ST_DRAW0, ST_DRAW1: begin
            cmd.op = mix_op;
            priority if (state_ff == ST_SEED) cmd.dst = DST_STATE;
            else if (state_ff == ST_DRAW0) cmd.dst = DST_K0;
            else cmd.dst = DST_K1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == MIX_LAST) begin
               cnt_in = 5'd0;
               priority if (state_ff == ST_SEED) state_in = ST_DRAW0;
               else if (state_ff == ST_DRAW0) state_in = ST_DRAW1;
               else state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.op = OP_PREP;
            cnt_in = 5'd0;
            state_in = ST_NORM;
         end
         ST_NORM: begin
            cmd.op = OP_NORM_STEP;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == NORM_LAST) state_in = ST_LOGI;
         end
         ST_LOGI: begin
            cmd.op = OP_LOG_INIT;
            cnt_in = 5'd0;
            state_in = ST_LOG;
         end
         ST_LOG: begin
            cmd.op = OP_LOG_STEP;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == ITER_LAST) state_in = ST_RAD;
         end
         ST_RAD: begin
            cmd.op = OP_RAD;
            cnt_in = 5'd0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.op = OP_SQRT_STEP;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == ITER_LAST) state_in = ST_SCA;
         end
         ST_SCA: begin
            cmd.op = OP_SCALE_A;
            state_in = ST_SCB;
         end
         ST_SCB: begin
            cmd.op = OP_SCALE_B;
            state_in = ST_OUT;
         end
         ST_OUT: if (out_go) begin
            cmd.op = OP_OUT;
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   // an accepted word starts the sequence
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != ST_IDLE)
      else $error("accepted word did not start");
   // mix micro-steps stay in range
   a_mix_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEED || state_ff == ST_DRAW0 || state_ff == ST_DRAW1)
      |-> cnt_ff <= MIX_LAST)
      else $error("mix step out of range");
   // a finished result is presented and the sequencer frees up
   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && out_go |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("result not presented");
`endif

endmodule

>>> verif/gaussian_pair_box_muller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_pair_box_muller_tb
// Drives seed words into the Gaussian pair generator with random gaps and
// random result stalls, predicts each normal pair from its own splitmix64
// state and fixed-point Box-Muller chain, and checks every result word.
// ----------------------------------------------------------------------------
module gaussian_pair_box_muller_tb;
   import gbm_pkg::*;

   localparam int NUM_RANDOM = 750;
   localparam int IDLE_LIMIT = 5000;

   // predicts gaussian pairs and holds the pairs still owed by the block
   class gauss_scoreboard;
      bit [63:0] gen_state;
      rsp_word_type owed_pairs[$];
      int n_errors;

      function new();
         gen_state = '0;
         n_errors = 0;
      endfunction

      function bit [63:0] splitmix_fin(bit [63:0] z);
         z = (z ^ (z >> 30)) * MULA;
         z = (z ^ (z >> 27)) * MULB;
         return z ^ (z >> 31);
      endfunction

      function bit [63:0] next_code();
         gen_state = gen_state + GOLD;
         return splitmix_fin(gen_state) >> 11;
      endfunction

      function bit [63:0] int_sqrt(bit [63:0] v);
         bit [63:0] root;
         bit [63:0] probe;
         root = 0;
         probe = 64'd1 << 62;
         while (probe > v) probe = probe >> 2;
         while (probe != 0) begin
            if (v >= root + probe) begin
               v = v - (root + probe);
               root = (root >> 1) + probe;
            end else begin
               root = root >> 1;
            end
            probe = probe >> 2;
         end
         return root;
      endfunction

      // sqrt(-2 ln(k/2^53)) in Q.28
      function bit [63:0] radius_of(bit [63:0] k);
         int top;
         bit [63:0] m, l2, d, y;
         if (k < MIN_CODE) k = MIN_CODE;
         top = 63;
         while (k[top] == 1'b0) top--;
         m = (top >= 31) ? (k >> (top - 31)) : (k << (31 - top));
         l2 = 64'(top) << 32;
         for (int i = 31; i >= 0; i--) begin
            m = (m * m) >> 31;
            if (m >= (64'd2 << 31)) begin
               l2[i] = 1'b1;
               m = m >> 1;
            end
         end
         d = (64'd53 << 32) - l2;
         y = ((d >> 4) * TWO_LN2_Q28 + (64'd1 << 27)) >> 28;
         return int_sqrt(y << 28);
      endfunction

      // radius times component, rounded half away from zero
      function logic signed [31:0] scale_to_q26(bit [63:0] r, longint comp);
         bit [63:0] mag, v;
         mag = (comp < 0) ? 64'(-comp) : 64'(comp);
         v = (r * mag + (64'd1 << 31)) >> 32;
         if (comp < 0) v = 64'd0 - v;
         return v[31:0];
      endfunction

      function void note_word(req_word_type w);
         bit [63:0] k0, k1, r, frac, ang;
         bit [1:0] quad;
         longint x, y, z, nx, c, s;
         rsp_word_type pair;
         if (w.load_seed) gen_state = splitmix_fin(w.seed + GOLD);
         k0 = next_code();
         k1 = next_code();
         r = radius_of(k0);
         quad = k1[52:51];
         frac = (k1 & ((64'd1 << 51) - 1)) >> 21;
         ang = (frac * HALF_PI_Q30) >> 30;
         x = CORDIC_K_Q30;
         y = 0;
         z = longint'(ang);
         // rotation steps, arithmetic shifts floor toward minus infinity
         for (int i = 0; i < 30; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i);
               y = y + (x >>> i);
               z = z - longint'(atan_q30(5'(i)));
            end else begin
               nx = x + (y >>> i);
               y = y - (x >>> i);
               z = z + longint'(atan_q30(5'(i)));
            end
            x = nx;
         end
         c = x;
         s = y;
         case (quad)
            2'd0: begin
               pair.gauss_a = scale_to_q26(r, c);
               pair.gauss_b = scale_to_q26(r, s);
            end
            2'd1: begin
               pair.gauss_a = scale_to_q26(r, -s);
               pair.gauss_b = scale_to_q26(r, c);
            end
            2'd2: begin
               pair.gauss_a = scale_to_q26(r, -c);
               pair.gauss_b = scale_to_q26(r, -s);
            end
            default: begin
               pair.gauss_a = scale_to_q26(r, s);
               pair.gauss_b = scale_to_q26(r, -c);
            end
         endcase
         owed_pairs.push_back(pair);
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type want;
         if (owed_pairs.size() == 0) begin
            $error("unexpected word: gauss_a %0d gauss_b %0d", got.gauss_a, got.gauss_b);
            n_errors++;
            return;
         end
         want = owed_pairs.pop_front();
         if (got.gauss_a !== want.gauss_a) begin
            $error("gauss_a: expected %0d, actual %0d", want.gauss_a, got.gauss_a);
            n_errors++;
         end
         if (got.gauss_b !== want.gauss_b) begin
            $error("gauss_b: expected %0d, actual %0d", want.gauss_b, got.gauss_b);
            n_errors++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_word;

   gauss_scoreboard sb;
   int idle_cycles;
   int stall_left;

   gaussian_pair_box_muller dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // mostly short gaps, sometimes a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 4) return 0;
      if (roll < 9) return $urandom_range(1, 4);
      return $urandom_range(20, 150);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // offer one word and hold it until taken, then maybe go idle
   task automatic send_word(req_word_type w);
      int gap;
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (!req_ready);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_seed(logic load, logic [63:0] value);
      req_word_type w;
      w.load_seed = load;
      w.seed = value;
      send_word(w);
   endtask

   // watch both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_word(req_word);
         if (rsp_valid && rsp_ready) sb.check_word(rsp_word);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // result side stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= (stall_left == 1);
      end else if (rsp_valid && rsp_ready || $urandom_range(0, 15) == 0) begin
         if (pick_gap() == 0) begin
            stall_left <= 0;
            rsp_ready <= 1'b1;
         end else begin
            stall_left <= pick_gap();
            rsp_ready <= 1'b0;
         end
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // no progress for too long
   always @(posedge clock) begin
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      sb = new();
      idle_cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: draws from reset state, seed extremes, ignored seed
      send_seed(1'b0, 64'd0);
      send_seed(1'b0, '1);
      send_seed(1'b1, 64'd0);
      send_seed(1'b0, 64'hAAAA_AAAA_AAAA_AAAA);
      send_seed(1'b1, '1);
      send_seed(1'b1, 64'h8000_0000_0000_0000);
      send_seed(1'b1, 64'd1);
      send_seed(1'b0, 64'h5555_5555_5555_5555);
      send_seed(1'b1, 64'h5555_5555_5555_5555);
      send_seed(1'b1, 64'hAAAA_AAAA_AAAA_AAAA);
      // seed that makes the first mixed state zero after the golden step
      send_seed(1'b1, 64'd0 - GOLD);
      send_seed(1'b0, rand64());

      // random: mostly free-running draws with occasional reseeds
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n == NUM_RANDOM / 2) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (sb.owed_pairs.size() != 0) @(posedge clock);
         end
         send_seed($urandom_range(0, 3) == 0, rand64());
      end
      req_valid <= 1'b0;

      while (sb.owed_pairs.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      if (sb.n_errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
